// ===== hw/rtl/lslc_pkg.sv =====
// Package with shared types, codes and helpers of the link status LED controller.
`default_nettype none
package lslc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_LINK_LOST = 2'd1,
    CMD_GOT_ADDR  = 2'd2,
    CMD_START     = 2'd3
  } cmd_e;

  localparam logic [1:0] MODE_CONNECTED    = 2'd0;
  localparam logic [1:0] MODE_CONNECTING   = 2'd1;
  localparam logic [1:0] MODE_DISCONNECTED = 2'd2;

  localparam logic [2:0] REG_LED_ACTIVE_LOW = 3'd0;
  localparam logic [2:0] REG_RETRY_INTERVAL = 3'd1;
  localparam logic [2:0] REG_ATTEMPT_TMO    = 3'd2;
  localparam logic [2:0] REG_TOGGLE_PERIOD  = 3'd3;
  localparam logic [2:0] REG_BLINK_ON       = 3'd4;
  localparam logic [2:0] REG_BLINK_OFF      = 3'd5;
  localparam logic [2:0] REG_PAUSE          = 3'd6;
  localparam logic [2:0] REG_BLINK_TOTAL    = 3'd7;

  localparam logic [15:0] RST_RETRY_INTERVAL = 16'd10000;
  localparam logic [15:0] RST_ATTEMPT_TMO    = 16'd20000;
  localparam logic [15:0] RST_TOGGLE_PERIOD  = 16'd400;
  localparam logic [15:0] RST_BLINK_ON       = 16'd200;
  localparam logic [15:0] RST_BLINK_OFF      = 16'd200;
  localparam logic [15:0] RST_PAUSE          = 16'd1500;
  localparam logic [3:0]  RST_BLINK_TOTAL    = 4'd3;

  typedef struct packed {
    logic        led_active_low;
    logic [15:0] retry_interval_ms;
    logic [15:0] attempt_timeout_ms;
    logic [15:0] toggle_period_ms;
    logic [15:0] blink_on_ms;
    logic [15:0] blink_off_ms;
    logic [15:0] pause_ms;
    logic [3:0]  blink_total;
  } cfg_t;

  typedef struct packed {
    logic       connect_request;
    logic       linked;
    logic [1:0] mode;
    logic       led_pin;
  } result_t;

  typedef struct packed {
    logic [1:0] led_mode;
    logic       lit;
    logic [3:0] blink_index;
  } state_view_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] at_least_one16(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lslc_cfg_regs.sv =====
// Configuration register file of the link status LED controller.
`default_nettype none
module lslc_cfg_regs
  import lslc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output      cfg_t        cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LED_ACTIVE_LOW: cfg_d.led_active_low     = cfg_data_i[0];
        REG_RETRY_INTERVAL: cfg_d.retry_interval_ms  = cfg_data_i;
        REG_ATTEMPT_TMO:    cfg_d.attempt_timeout_ms = cfg_data_i;
        REG_TOGGLE_PERIOD:  cfg_d.toggle_period_ms   = cfg_data_i;
        REG_BLINK_ON:       cfg_d.blink_on_ms        = cfg_data_i;
        REG_BLINK_OFF:      cfg_d.blink_off_ms       = cfg_data_i;
        REG_PAUSE:          cfg_d.pause_ms           = cfg_data_i;
        REG_BLINK_TOTAL:    cfg_d.blink_total        = cfg_data_i[3:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.led_active_low     <= 1'b0;
      cfg_q.retry_interval_ms  <= RST_RETRY_INTERVAL;
      cfg_q.attempt_timeout_ms <= RST_ATTEMPT_TMO;
      cfg_q.toggle_period_ms   <= RST_TOGGLE_PERIOD;
      cfg_q.blink_on_ms        <= RST_BLINK_ON;
      cfg_q.blink_off_ms       <= RST_BLINK_OFF;
      cfg_q.pause_ms           <= RST_PAUSE;
      cfg_q.blink_total        <= RST_BLINK_TOTAL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lslc_state.sv =====
// Link and LED state registers with the per-beat update logic.
`default_nettype none
module lslc_state
  import lslc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire cmd_e        cmd_i,
  input  wire logic        hard_failure_i,
  input  wire cfg_t        cfg_i,
  output      result_t     result_o,
  output      state_view_t view_o
);

  logic        link_up_q, link_up_d;
  logic        failed_hard_q, failed_hard_d;
  logic [1:0]  led_mode_q, led_mode_d;
  logic [15:0] phase_ms_q, phase_ms_d;
  logic        phase_level_q, phase_level_d;
  logic [3:0]  blink_index_q, blink_index_d;
  logic [15:0] since_attempt_q, since_attempt_d;
  logic [15:0] since_retry_q, since_retry_d;
  logic        lit_q, lit_d;

  logic        req;
  logic [3:0]  total;
  logic [3:0]  bi_inc;
  logic [15:0] seg_len;
  logic        in_pause;
  logic [1:0]  target;

  always_comb begin
    link_up_d       = link_up_q;
    failed_hard_d   = failed_hard_q;
    led_mode_d      = led_mode_q;
    phase_ms_d      = phase_ms_q;
    phase_level_d   = phase_level_q;
    blink_index_d   = blink_index_q;
    since_attempt_d = since_attempt_q;
    since_retry_d   = since_retry_q;
    lit_d           = lit_q;
    req             = 1'b0;
    total           = (cfg_i.blink_total == 4'd0) ? 4'd1 : cfg_i.blink_total;
    bi_inc          = blink_index_q + 4'd1;
    in_pause        = (blink_index_q >= total);
    seg_len         = 16'd0;
    target          = MODE_CONNECTING;

    case (cmd_i)
      CMD_TICK: begin
        since_attempt_d = sat_inc16(since_attempt_q);
        since_retry_d   = sat_inc16(since_retry_q);
        phase_ms_d      = sat_inc16(phase_ms_q);

        if (led_mode_q == MODE_CONNECTING) begin
          if (phase_ms_d >= at_least_one16(cfg_i.toggle_period_ms)) begin
            phase_ms_d    = 16'd0;
            phase_level_d = ~phase_level_q;
          end
        end else if (led_mode_q == MODE_DISCONNECTED) begin
          if (in_pause) begin
            seg_len = cfg_i.pause_ms;
          end else if (phase_level_q) begin
            seg_len = at_least_one16(cfg_i.blink_on_ms);
          end else begin
            seg_len = at_least_one16(cfg_i.blink_off_ms);
          end
          if (phase_ms_d >= seg_len) begin
            phase_ms_d = 16'd0;
            if (in_pause) begin
              blink_index_d = 4'd0;
              phase_level_d = 1'b1;
            end else if (phase_level_q) begin
              phase_level_d = 1'b0;
            end else begin
              phase_level_d = 1'b1;
              if (bi_inc >= total && cfg_i.pause_ms == 16'd0) begin
                blink_index_d = 4'd0;
              end else begin
                blink_index_d = bi_inc;
              end
            end
          end
        end

        if (link_up_q) begin
          target = MODE_CONNECTED;
        end else if (failed_hard_q || since_attempt_d >= cfg_i.attempt_timeout_ms) begin
          target = MODE_DISCONNECTED;
        end else begin
          target = MODE_CONNECTING;
        end
        if (led_mode_d != target) begin
          led_mode_d    = target;
          phase_ms_d    = 16'd0;
          phase_level_d = 1'b1;
          blink_index_d = 4'd0;
        end

        if (led_mode_d == MODE_CONNECTED) begin
          lit_d = 1'b1;
        end else if (led_mode_d == MODE_CONNECTING) begin
          lit_d = phase_level_d;
        end else begin
          lit_d = (blink_index_d < total) ? phase_level_d : 1'b0;
        end

        if (!link_up_q && since_retry_d >= cfg_i.retry_interval_ms) begin
          since_retry_d   = 16'd0;
          since_attempt_d = 16'd0;
          failed_hard_d   = 1'b0;
          req             = 1'b1;
          if (led_mode_d != MODE_CONNECTING) begin
            led_mode_d    = MODE_CONNECTING;
            phase_ms_d    = 16'd0;
            phase_level_d = 1'b1;
            blink_index_d = 4'd0;
            lit_d         = 1'b0;
          end
        end
      end
      CMD_LINK_LOST: begin
        link_up_d       = 1'b0;
        failed_hard_d   = hard_failure_i;
        since_attempt_d = 16'd0;
        req             = 1'b1;
        if (led_mode_q != MODE_CONNECTING) begin
          led_mode_d    = MODE_CONNECTING;
          phase_ms_d    = 16'd0;
          phase_level_d = 1'b1;
          blink_index_d = 4'd0;
          lit_d         = 1'b0;
        end
      end
      CMD_GOT_ADDR: begin
        link_up_d     = 1'b1;
        failed_hard_d = 1'b0;
        if (led_mode_q != MODE_CONNECTED) begin
          led_mode_d    = MODE_CONNECTED;
          phase_ms_d    = 16'd0;
          phase_level_d = 1'b1;
          blink_index_d = 4'd0;
          lit_d         = 1'b1;
        end
      end
      default: begin
        since_attempt_d = 16'd0;
        since_retry_d   = 16'd0;
        failed_hard_d   = 1'b0;
        req             = 1'b1;
        if (led_mode_q != MODE_CONNECTING) begin
          led_mode_d    = MODE_CONNECTING;
          phase_ms_d    = 16'd0;
          phase_level_d = 1'b1;
          blink_index_d = 4'd0;
          lit_d         = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_up_q       <= 1'b0;
      failed_hard_q   <= 1'b0;
      led_mode_q      <= MODE_CONNECTING;
      phase_ms_q      <= 16'd0;
      phase_level_q   <= 1'b1;
      blink_index_q   <= 4'd0;
      since_attempt_q <= 16'd0;
      since_retry_q   <= 16'd0;
      lit_q           <= 1'b0;
    end else if (step_i) begin
      link_up_q       <= link_up_d;
      failed_hard_q   <= failed_hard_d;
      led_mode_q      <= led_mode_d;
      phase_ms_q      <= phase_ms_d;
      phase_level_q   <= phase_level_d;
      blink_index_q   <= blink_index_d;
      since_attempt_q <= since_attempt_d;
      since_retry_q   <= since_retry_d;
      lit_q           <= lit_d;
    end
  end

  assign result_o.led_pin         = lit_d ^ cfg_i.led_active_low;
  assign result_o.mode            = led_mode_d;
  assign result_o.linked          = link_up_d;
  assign result_o.connect_request = req;

  assign view_o.led_mode    = led_mode_q;
  assign view_o.lit         = lit_q;
  assign view_o.blink_index = blink_index_q;

endmodule
`default_nettype wire

// ===== hw/rtl/link_status_led_controller.sv =====
// A beat waits in the input register; its result is held in the result register.
// Throughput: one beat per cycle unless the output stalls. The state update
// between the two registers is a single pass of counter increments and compares.
// A stalled output holds its beat while the input register still takes one more.
// Reset (asynchronous, active low) restores the register defaults and the
// connecting mode with the LED off; no beat is pending after reset.
`default_nettype none
module link_status_led_controller
  import lslc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [0] hard_failure, [7:1] zero
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,  // [0] led_pin, [2:1] mode, [3] linked,
                                          // [4] connect_request, [7:5] zero
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t        cfg;
  result_t     result;
  state_view_t view;

  logic        in_valid_q;
  cmd_e        in_cmd_q;
  logic        in_hard_q;
  logic        out_valid_q;
  result_t     out_q;
  logic        advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  lslc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lslc_state u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .cmd_i          (in_cmd_q),
    .hard_failure_i (in_hard_q),
    .cfg_i          (cfg),
    .result_o       (result),
    .view_o         (view)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q  <= cmd_e'(s_axis_tuser);
      in_hard_q <= s_axis_tdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.connect_request, out_q.linked, out_q.mode,
                          out_q.led_pin};

  a_connected_lit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    view.led_mode == MODE_CONNECTED |-> view.lit)
    else $error("LED is dark while the mode is connected");

  a_blinks_only_disconnected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    view.led_mode != MODE_DISCONNECTED |-> view.blink_index == 4'd0)
    else $error("Blink count is set outside the disconnected mode");

  a_request_connecting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && result.connect_request) |=> (out_q.mode == MODE_CONNECTING))
    else $error("Connect request issued without the connecting mode");

  a_state_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(view))
    else $error("State changed without a beat being processed");

endmodule
`default_nettype wire
